>>> rtl/slxfd_pkg.sv
// Package: byte codes, result events and parser phases for the sync/length/XOR frame decoder.
`timescale 1ns / 1ps

package slxfd_pkg;

  localparam logic [7:0] SYNC_0    = 8'h55;  // 'U'
  localparam logic [7:0] SYNC_1    = 8'h4E;  // 'N'
  localparam logic [7:0] SYNC_2    = 8'h45;  // 'E'
  localparam logic [7:0] SYNC_3    = 8'h52;  // 'R'
  localparam logic [7:0] SEPARATOR = 8'h3A;  // ':'

  // Checksum seed, minus the length byte, which is folded in at run time.
  localparam logic [7:0] SYNC_XOR = SYNC_0 ^ SYNC_1 ^ SYNC_2 ^ SYNC_3 ^ SEPARATOR;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_PAYLOAD = 3'd1;
  localparam logic [2:0] EV_GOOD    = 3'd2;
  localparam logic [2:0] EV_BAD_SUM = 3'd3;
  localparam logic [2:0] EV_FRAMING = 3'd4;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_SYNC1   = 8'b0000_0010,
    PH_SYNC2   = 8'b0000_0100,
    PH_SYNC3   = 8'b0000_1000,
    PH_LENGTH  = 8'b0001_0000,
    PH_SEP     = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CHECK   = 8'b1000_0000
  } phase_t;

endpackage

>>> rtl/sync_length_xor_frame_decoder.sv
// Top level: byte-wise sync word / length / XOR checksum frame decoder.
//
//   channel | handshake             | beat payload
//   --------+-----------------------+----------------------------------------------
//   in      | in_valid / in_ready   | rx_byte
//   out     | out_valid / out_ready | event_res, payload_byte, payload_index,
//           |                       | payload_count
//
// One result beat per input beat; the result is valid in the cycle after accept.
// Sustains one beat per cycle while out_ready is high; the single output register sets the latency.
// in_ready drops only while a result is held and out_ready is low.
// rst (synchronous) returns the parser to sync hunting and empties the output.
`timescale 1ns / 1ps

module sync_length_xor_frame_decoder
  import slxfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] payload_count
);

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] next_index, next_index_next;

  logic [2:0] ev_next;
  logic [7:0] pbyte_next, pidx_next, pcount_next;
  logic [7:0] left_dec;
  logic       accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    bytes_left_next  = bytes_left;
    next_index_next  = next_index;
    ev_next          = EV_NONE;
    pbyte_next       = '0;
    pidx_next        = '0;
    pcount_next      = '0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_0) phase_next = PH_SYNC1;
      end
      PH_SYNC1: begin
        if (rx_byte == SYNC_1) begin
          phase_next = PH_SYNC2;
        end else begin
          phase_next = PH_HUNT;
          ev_next    = EV_FRAMING;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC_2) begin
          phase_next = PH_SYNC3;
        end else begin
          phase_next = PH_HUNT;
          ev_next    = EV_FRAMING;
        end
      end
      PH_SYNC3: begin
        if (rx_byte == SYNC_3) begin
          phase_next = PH_LENGTH;
        end else begin
          phase_next = PH_HUNT;
          ev_next    = EV_FRAMING;
        end
      end
      PH_LENGTH: begin
        if (rx_byte == 8'd0) begin
          phase_next = PH_HUNT;
          ev_next    = EV_FRAMING;
        end else begin
          bytes_left_next = rx_byte;
          phase_next      = PH_SEP;
        end
      end
      PH_SEP: begin
        if (rx_byte == SEPARATOR) begin
          // bytes_left still holds the length byte here
          running_xor_next = SYNC_XOR ^ bytes_left;
          bytes_left_next  = left_dec;
          next_index_next  = '0;
          phase_next       = (left_dec == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          phase_next = PH_HUNT;
          ev_next    = EV_FRAMING;
        end
      end
      PH_PAYLOAD: begin
        ev_next          = EV_PAYLOAD;
        pbyte_next       = rx_byte;
        pidx_next        = next_index;
        running_xor_next = running_xor ^ rx_byte;
        next_index_next  = next_index + 8'd1;
        bytes_left_next  = left_dec;
        if (left_dec == 8'd0) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        ev_next     = (running_xor == rx_byte) ? EV_GOOD : EV_BAD_SUM;
        pcount_next = next_index;
        phase_next  = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_xor <= '0;
      bytes_left  <= '0;
      next_index  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      bytes_left  <= bytes_left_next;
      next_index  <= next_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_res     <= ev_next;
      payload_byte  <= pbyte_next;
      payload_index <= pidx_next;
      payload_count <= pcount_next;
    end
  end

`ifndef ASSERT_OFF
  // a checksum byte always closes the frame
  a_check_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_CHECK) |=> (phase == PH_HUNT))
    else $error("phase did not return to hunt after checksum beat");

  // only payload beats carry byte and index
  a_fields_zero_off_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_PAYLOAD) |-> (payload_byte == 8'd0 && payload_index == 8'd0))
    else $error("payload fields nonzero on a non-payload beat");

  // count is reported only with a checksum verdict
  a_count_only_on_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_GOOD && event_res != EV_BAD_SUM) |-> (payload_count == 8'd0))
    else $error("payload_count nonzero without a checksum verdict");
`endif

endmodule
